FILE: hw/rtl/wctpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wctpp_pkg
// Shared constants, types and the well-known parameter coding table for the
// WSP content-type parameter parser.
// ----------------------------------------------------------------------------
package wctpp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned LEFT_W  = 5;
    localparam int unsigned TOKEN_W = 32;

    localparam logic [BYTE_W-1:0] NO_SEC_RESET  = 8'hff;
    localparam logic [BYTE_W-1:0] LEAD_CT_CODE  = 8'hb6;
    localparam logic [BYTE_W-1:0] SHORT_MASK    = 8'h7f;
    localparam logic [BYTE_W-1:0] MAX_LONG_LEN  = 8'd30;
    localparam logic [BYTE_W-1:0] QUOTE_TSTRING = 8'd127;
    localparam logic [BYTE_W-1:0] QUOTE_TVALUE  = 8'd34;
    localparam logic [LEFT_W-1:0] MAX_SKIP      = 5'd31;

    localparam logic [TOKEN_W-1:0] NUM_TOKENS = 32'd30;
    localparam logic [TOKEN_W-1:0] TOKEN_SEC  = 32'h11;
    localparam logic [TOKEN_W-1:0] TOKEN_MAC  = 32'h12;

    // value codings
    localparam logic [CODE_W-1:0] C_QVAL    = 4'd0;
    localparam logic [CODE_W-1:0] C_CHARSET = 4'd1;
    localparam logic [CODE_W-1:0] C_VERSION = 4'd2;
    localparam logic [CODE_W-1:0] C_INTEGER = 4'd3;
    localparam logic [CODE_W-1:0] C_TSTRING = 4'd4;
    localparam logic [CODE_W-1:0] C_FIELD   = 4'd5;
    localparam logic [CODE_W-1:0] C_SHORT   = 4'd6;
    localparam logic [CODE_W-1:0] C_CONSTR  = 4'd7;
    localparam logic [CODE_W-1:0] C_DELTA   = 4'd8;
    localparam logic [CODE_W-1:0] C_NOVAL   = 4'd9;
    localparam logic [CODE_W-1:0] C_TVALUE  = 4'd10;
    localparam logic [CODE_W-1:0] C_DATE    = 4'd11;

    // one result item
    typedef struct packed {
        logic              mac_begin;
        logic              mac_valid;
        logic [BYTE_W-1:0] mac_byte;
        logic [BYTE_W-1:0] sec_code;
        logic              header_done;
    } result_t;

    // value coding of a well-known token below NUM_TOKENS
    function automatic logic [CODE_W-1:0] token_coding(input logic [4:0] tok);
        logic [CODE_W-1:0] c;
        unique case (tok)
            5'd0:  c = C_QVAL;
            5'd1:  c = C_CHARSET;
            5'd2:  c = C_VERSION;
            5'd3:  c = C_INTEGER;
            5'd4:  c = C_NOVAL;
            5'd5:  c = C_TSTRING;
            5'd6:  c = C_TSTRING;
            5'd7:  c = C_FIELD;
            5'd8:  c = C_SHORT;
            5'd9:  c = C_CONSTR;
            5'd10: c = C_TSTRING;
            5'd11: c = C_TSTRING;
            5'd12: c = C_TSTRING;
            5'd13: c = C_TSTRING;
            5'd14: c = C_DELTA;
            5'd15: c = C_TSTRING;
            5'd16: c = C_NOVAL;
            5'd17: c = C_SHORT;
            5'd18: c = C_TVALUE;
            5'd19: c = C_DATE;
            5'd20: c = C_DATE;
            5'd21: c = C_DATE;
            5'd22: c = C_INTEGER;
            default: c = C_TVALUE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/wsp_content_type_param_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Each result is registered in out_reg, or in skid_reg while out_reg is stalled.
// Throughput: one byte per cycle while skid_reg is empty; per-byte parser update is
//   one combinational pass, and skid keeps s_tready high while one result waits.
// Reset (rst_n low, asynchronous): parser at parameter start, output stage empty,
//   no_sec_code back to 255.
// ----------------------------------------------------------------------------
// wsp_content_type_param_parser_unit
// Byte-wise decoder of binary WSP content-type parameters. Skips a leading
// content-type code, walks well-known and unknown parameters, keeps the SEC
// short integer and streams the MAC text value out.
// ----------------------------------------------------------------------------
module wsp_content_type_param_parser_unit
    import wctpp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration: no_sec_code
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [BYTE_W-1:0] cfg_data,
    // header bytes in
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] header_byte
    input  wire logic              s_tlast,   // header_last
    // results out
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // [7:0] mac_byte, [15:8] sec_code
    output logic [1:0]             m_tuser,   // [0] mac_begin, [1] mac_valid
    output logic                   m_tlast    // header_done
);

    // parse phases
    localparam logic [PHASE_W-1:0] PH_START   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TOKLEN  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_VALUE   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_QVAL    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SKIP    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_TONUL   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_UNKNAME = 3'd6;
    localparam logic [PHASE_W-1:0] PH_UNKVAL  = 3'd7;

    // parser state
    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic [LEFT_W-1:0]  left_reg,   left_next;
    logic [TOKEN_W-1:0] token_reg,  token_next;
    logic [CODE_W-1:0]  coding_reg, coding_next;
    logic [BYTE_W-1:0]  sec_reg,    sec_next;
    logic               first_reg,  first_next;
    logic               capt_reg,   capt_next;
    logic [BYTE_W-1:0]  no_sec_reg;

    // output register plus skid stage
    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_valid_reg;

    logic in_xfer, out_xfer;
    logic [BYTE_W-1:0] b;
    logic skip_lead;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = out_valid_reg && m_tready;
    assign b         = s_tdata;

    // configuration register; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_sec_reg <= NO_SEC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            no_sec_reg <= cfg_data;
        end
    end

    // next parser state and result for the byte on s_tdata
    always_comb
    begin
        logic [LEFT_W-1:0]  sat_len;
        logic               is_mac;
        logic [BYTE_W-1:0]  quote;
        logic               do_text;
        logic               do_skip;
        logic               do_finish;

        phase_next  = phase_reg;
        left_next   = left_reg;
        token_next  = token_reg;
        coding_next = coding_reg;
        sec_next    = sec_reg;
        first_next  = first_reg;
        capt_next   = capt_reg;
        res_next    = '0;
        skip_lead   = 1'b0;
        is_mac      = 1'b0;
        quote       = QUOTE_TSTRING;
        do_text     = 1'b0;
        do_skip     = 1'b0;
        do_finish   = 1'b0;
        sat_len     = (b > {3'b000, MAX_SKIP}) ? MAX_SKIP : b[LEFT_W-1:0];

        // new header: SEC falls back to the configured code
        if (first_reg)
        begin
            sec_next   = no_sec_reg;
            first_next = 1'b0;
            skip_lead  = (b == LEAD_CT_CODE);
        end

        if (!skip_lead)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (b > SHORT_MASK)
                    begin
                        token_next = {{(TOKEN_W-BYTE_W){1'b0}}, b & SHORT_MASK};
                        do_finish  = 1'b1;
                    end
                    else if (b <= MAX_LONG_LEN)
                    begin
                        token_next = '0;
                        if (b == '0)
                        begin
                            do_finish = 1'b1;
                        end
                        else
                        begin
                            left_next  = b[LEFT_W-1:0];
                            phase_next = PH_TOKLEN;
                        end
                    end
                    else
                    begin
                        phase_next = PH_UNKNAME;
                    end
                end
                PH_TOKLEN:
                begin
                    token_next = {token_reg[TOKEN_W-BYTE_W-1:0], b};
                    left_next  = left_reg - LEFT_W'(1);
                    do_finish  = (left_next == '0);
                end
                PH_VALUE:
                begin
                    phase_next = PH_START;
                    case (coding_reg)
                        C_QVAL:
                        begin
                            if (b[7])
                            begin
                                phase_next = PH_QVAL;
                            end
                        end
                        C_CHARSET, C_INTEGER, C_DELTA:
                        begin
                            do_skip = (b <= SHORT_MASK);
                        end
                        C_VERSION:
                        begin
                            do_text = (b <= SHORT_MASK);
                        end
                        C_TSTRING:
                        begin
                            do_text = 1'b1;
                        end
                        C_FIELD, C_CONSTR:
                        begin
                            if (b <= SHORT_MASK && b != '0)
                            begin
                                phase_next = PH_TONUL;
                            end
                        end
                        C_SHORT:
                        begin
                            if (token_reg == TOKEN_SEC)
                            begin
                                sec_next = b & SHORT_MASK;
                            end
                        end
                        C_TVALUE:
                        begin
                            do_text = 1'b1;
                            quote   = QUOTE_TVALUE;
                            is_mac  = (token_reg == TOKEN_MAC);
                        end
                        C_DATE:
                        begin
                            do_skip = 1'b1;
                        end
                        default:
                        begin
                            // no-value and unused codes consume the byte
                        end
                    endcase
                end
                PH_QVAL:
                begin
                    if (!b[7])
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_reg - LEFT_W'(1);
                    if (left_next == '0)
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_TONUL:
                begin
                    if (b == '0)
                    begin
                        phase_next = PH_START;
                        capt_next  = 1'b0;
                    end
                    else if (capt_reg)
                    begin
                        res_next.mac_valid = 1'b1;
                        res_next.mac_byte  = b;
                    end
                end
                PH_UNKNAME:
                begin
                    if (b == '0)
                    begin
                        phase_next = PH_UNKVAL;
                    end
                end
                PH_UNKVAL:
                begin
                    phase_next = PH_START;
                    if (b > SHORT_MASK)
                    begin
                        // one-byte short integer
                    end
                    else if (b <= MAX_LONG_LEN)
                    begin
                        do_skip = 1'b1;
                    end
                    else
                    begin
                        do_text = 1'b1;
                        quote   = QUOTE_TVALUE;
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end

        // token complete: look up its value coding
        if (do_finish)
        begin
            if (token_next < NUM_TOKENS)
            begin
                coding_next = token_coding(token_next[4:0]);
                phase_next  = PH_VALUE;
            end
            else
            begin
                phase_next = PH_START;
            end
        end

        // length-prefixed value, saturated
        if (do_skip)
        begin
            if (sat_len == '0)
            begin
                phase_next = PH_START;
            end
            else
            begin
                left_next  = sat_len;
                phase_next = PH_SKIP;
            end
        end

        // text value with optional leading quote
        if (do_text)
        begin
            if (is_mac)
            begin
                res_next.mac_begin = 1'b1;
            end
            if (b == quote)
            begin
                phase_next = PH_TONUL;
            end
            else if (b == '0)
            begin
                phase_next = PH_START;
            end
            else
            begin
                phase_next = PH_TONUL;
                if (is_mac)
                begin
                    res_next.mac_valid = 1'b1;
                    res_next.mac_byte  = b;
                end
            end
            capt_next = is_mac && (phase_next == PH_TONUL);
        end

        // header end: a token cut off before its value
        if (s_tlast)
        begin
            if (phase_next == PH_VALUE)
            begin
                if (token_next == TOKEN_SEC)
                begin
                    sec_next = '0;
                end
                else if (token_next == TOKEN_MAC)
                begin
                    res_next.mac_begin = 1'b1;
                end
            end
            phase_next = PH_START;
            left_next  = '0;
            capt_next  = 1'b0;
            first_next = 1'b1;
        end

        res_next.sec_code    = sec_next;
        res_next.header_done = s_tlast;
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            left_reg   <= '0;
            token_reg  <= '0;
            coding_reg <= C_QVAL;
            sec_reg    <= NO_SEC_RESET;
            first_reg  <= 1'b1;
            capt_reg   <= 1'b0;
        end
        else if (in_xfer)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            token_reg  <= token_next;
            coding_reg <= coding_next;
            sec_reg    <= sec_next;
            first_reg  <= first_next;
            capt_reg   <= capt_next;
        end
    end

    // output stage control: results land in out_reg, or in skid_reg while
    // out_reg is held by a stalled sink
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_xfer)
            begin
                out_valid_reg  <= skid_valid_reg || in_xfer;
                skid_valid_reg <= 1'b0;
            end
            else if (in_xfer)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // output stage payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_xfer)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_next;
        end
        if (in_xfer && out_valid_reg && !out_xfer)
        begin
            skid_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.sec_code, out_reg.mac_byte};
    assign m_tuser  = {out_reg.mac_valid, out_reg.mac_begin};
    assign m_tlast  = out_reg.header_done;

endmodule
`default_nettype wire
